### hdl/fsnsu_pkg.sv
package fsnsu_pkg;

  localparam int          MAX_RESULTS = 64;
  localparam logic [20:0] PHASE_ONE   = 21'd65536;
  localparam logic [20:0] PHASE_MAX   = 21'h1FFFFF;
  localparam logic [20:0] PHASE_STEP_RST = 21'd65536;
  localparam logic [6:0]  TAP_COUNT_RST  = 7'd64;

  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_TAP_COUNT  = 1'b1;

  localparam logic OP_LOAD_TAP = 1'b0;
  localparam logic OP_PUSH     = 1'b1;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_MAC   = 11'b000_0000_0100,
    ST_FILT  = 11'b000_0000_1000,
    ST_WARM  = 11'b000_0001_0000,
    ST_LOOP  = 11'b000_0010_0000,
    ST_N2    = 11'b000_0100_0000,
    ST_N3    = 11'b000_1000_0000,
    ST_COEF  = 11'b001_0000_0000,
    ST_TERM  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic clear;
    logic load_tap;
    logic push;
    logic mac_step;
    logic filt;
    logic n2;
    logic n3;
    logic coef;
    logic term_step;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic k_done;
    logic term_done;
    logic busy;
    logic warm;
    logic loop_go;
    logic out_free;
  } sts_t;

  function automatic logic signed [17:0] sat18(input logic signed [63:0] x);
    logic signed [17:0] r;
    if (x > 64'sd131071) r = 18'sh1FFFF;
    else if (x < -64'sd131072) r = 18'sh20000;
    else r = x[17:0];
    return r;
  endfunction

endpackage

### hdl/fsnsu_ifs.sv
interface fsnsu_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [5:0]         tap_index;
  logic signed [15:0] tap_value;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  modport source (output valid, op, tap_index, tap_value, sample_re, sample_im, input ready);
  modport sink   (input valid, op, tap_index, tap_value, sample_re, sample_im, output ready);
endinterface

interface fsnsu_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] out_re;
  logic signed [17:0] out_im;
  logic               last_of_run;
  modport source (output valid, out_re, out_im, last_of_run, input ready);
  modport sink   (input valid, out_re, out_im, last_of_run, output ready);
endinterface

interface fsnsu_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [20:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/fsnsu_ctrl.sv
module fsnsu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           in_op,
  input  fsnsu_pkg::sts_t sts,
  output fsnsu_pkg::cmd_t cmd,
  output logic           idle
);
  import fsnsu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_PUSH) begin
            cmd.push  = 1'b1;
            state_nxt = ST_MAC;
          end else begin
            cmd.load_tap = 1'b1;
          end
        end
      end
      ST_MAC: begin
        cmd.mac_step = !sts.k_done;
        if (sts.k_done && !sts.busy) state_nxt = ST_FILT;
      end
      ST_FILT: begin
        cmd.filt  = 1'b1;
        state_nxt = ST_WARM;
      end
      ST_WARM: state_nxt = sts.warm ? ST_LOOP : ST_IDLE;
      ST_LOOP: begin
        if (sts.loop_go) begin
          state_nxt = ST_N2;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_N2: begin
        cmd.n2    = 1'b1;
        state_nxt = ST_N3;
      end
      ST_N3: begin
        cmd.n3    = 1'b1;
        state_nxt = ST_COEF;
      end
      ST_COEF: begin
        cmd.coef  = 1'b1;
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        cmd.term_step = !sts.term_done;
        if (sts.term_done && !sts.busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_LOOP;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign idle = (state_r == ST_IDLE);

endmodule

### hdl/fsnsu_dp.sv
module fsnsu_dp #(
  parameter int MAX_TAPS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fsnsu_pkg::cmd_t    cmd,
  output fsnsu_pkg::sts_t    sts,
  input  logic [5:0]         tap_index,
  input  logic signed [15:0] tap_value,
  input  logic signed [15:0] sample_re,
  input  logic signed [15:0] sample_im,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [20:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [17:0] out_re,
  output logic signed [17:0] out_im,
  output logic               out_last
);
  import fsnsu_pkg::*;

  localparam int AW  = $clog2(MAX_TAPS);
  localparam int HD  = 1 << AW;
  localparam int KW  = $clog2(MAX_TAPS + 1);
  localparam int WW  = $clog2(MAX_TAPS + 4);
  localparam int FAW = 32 + AW;
  localparam int CW  = 37;
  localparam int DW  = 19;
  localparam int PW  = CW + DW;
  localparam int IAW = PW + 2;

  logic signed [15:0] tap_mem [HD];
  logic [31:0]        hist_mem [HD];

  logic [20:0]        phase_step_r;
  logic [6:0]         tap_count_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [AW-1:0]      wp_r;
  logic [KW-1:0]      k_r;
  logic [KW-1:0]      ntaps;
  logic [WW-1:0]      warmup_r;
  logic [20:0]        phase_r;
  logic [6:0]         cnt_r;
  logic [2:0]         j_r;
  logic               v1_r, v2_r, tv_r;

  logic signed [15:0] tap_rd_r, hist_re_r, hist_im_r;
  logic signed [31:0] fprod_re_r, fprod_im_r;
  logic signed [FAW-1:0] facc_re_r, facc_im_r, frnd_re, frnd_im;
  logic signed [17:0] win_re_r [4];
  logic signed [17:0] win_im_r [4];
  logic [31:0]        n2_r, n3_r;
  logic [47:0]        n3_full;
  logic signed [CW-1:0] coef_r [4];
  logic signed [CW-1:0] n_s, n2_s, n3_s;
  logic signed [DW-1:0] d_re, d_im;
  logic signed [PW-1:0] iprod_re_r, iprod_im_r;
  logic signed [IAW-1:0] iacc_re_r, iacc_im_r, irnd_re, irnd_im;
  logic [21:0]        phase_sum;
  logic [20:0]        phase_sat;
  logic               last;
  logic               out_valid_r, out_last_r;
  logic signed [17:0] out_re_r, out_im_r;

  always_comb begin
    if (32'(tap_count_r) >= MAX_TAPS) ntaps = KW'(MAX_TAPS);
    else                              ntaps = KW'(tap_count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      tap_mem[clr_cnt_r]  <= '0;
      hist_mem[clr_cnt_r] <= '0;
    end else begin
      if (cmd.load_tap && (32'(tap_index) < MAX_TAPS)) tap_mem[AW'(tap_index)] <= tap_value;
      if (cmd.push) hist_mem[wp_r + AW'(1)] <= {sample_re, sample_im};
    end
    tap_rd_r               <= tap_mem[k_r[AW-1:0]];
    {hist_re_r, hist_im_r} <= hist_mem[wp_r - k_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      tap_count_r  <= TAP_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP: phase_step_r <= cfg_data;
        REG_TAP_COUNT:  tap_count_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // filter MAC
  assign frnd_re = facc_re_r + (FAW'(1) << 14);
  assign frnd_im = facc_im_r + (FAW'(1) << 14);

  always_ff @(posedge clk) begin
    fprod_re_r <= 32'(tap_rd_r) * 32'(hist_re_r);
    fprod_im_r <= 32'(tap_rd_r) * 32'(hist_im_r);
    if (!rst_n) begin
      clr_cnt_r <= '0;
      wp_r      <= '0;
      k_r       <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      warmup_r  <= '0;
      for (int i = 0; i < 4; i++) begin
        win_re_r[i] <= '0;
        win_im_r[i] <= '0;
      end
    end else begin
      v1_r <= cmd.mac_step;
      v2_r <= v1_r;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.push) begin
        wp_r      <= wp_r + AW'(1);
        k_r       <= '0;
        facc_re_r <= '0;
        facc_im_r <= '0;
      end
      if (cmd.mac_step) k_r <= k_r + KW'(1);
      if (v2_r) begin
        facc_re_r <= facc_re_r + FAW'(fprod_re_r);
        facc_im_r <= facc_im_r + FAW'(fprod_im_r);
      end
      if (cmd.filt) begin
        for (int i = 0; i < 3; i++) begin
          win_re_r[i] <= win_re_r[i+1];
          win_im_r[i] <= win_im_r[i+1];
        end
        win_re_r[3] <= sat18(64'(frnd_re >>> 15));
        win_im_r[3] <= sat18(64'(frnd_im >>> 15));
        if (32'(warmup_r) < MAX_TAPS + 3) warmup_r <= warmup_r + WW'(1);
      end
    end
  end

  // interpolation
  assign n3_full = 48'(n2_r) * 48'(phase_r[15:0]);
  assign n_s     = CW'(phase_r[15:0]);
  assign n2_s    = CW'(n2_r);
  assign n3_s    = CW'(n3_r);

  always_comb begin
    case (j_r[1:0])
      2'd0: begin
        d_re = DW'(win_re_r[1]);
        d_im = DW'(win_im_r[1]);
      end
      2'd1: begin
        d_re = DW'(win_re_r[2]) - DW'(win_re_r[0]);
        d_im = DW'(win_im_r[2]) - DW'(win_im_r[0]);
      end
      2'd2: begin
        d_re = DW'(win_re_r[2]);
        d_im = DW'(win_im_r[2]);
      end
      default: begin
        d_re = DW'(win_re_r[3]) - DW'(win_re_r[1]);
        d_im = DW'(win_im_r[3]) - DW'(win_im_r[1]);
      end
    endcase
  end

  assign irnd_re   = iacc_re_r + (IAW'(1) << 32);
  assign irnd_im   = iacc_im_r + (IAW'(1) << 32);
  assign phase_sum = {1'b0, phase_r} + {1'b0, phase_step_r};
  assign phase_sat = phase_sum[21] ? PHASE_MAX : phase_sum[20:0];
  assign last      = (phase_sat >= PHASE_ONE) || (cnt_r == 7'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    iprod_re_r <= PW'(coef_r[j_r[1:0]]) * PW'(d_re);
    iprod_im_r <= PW'(coef_r[j_r[1:0]]) * PW'(d_im);
    if (cmd.n2) n2_r <= 32'(phase_r[15:0]) * 32'(phase_r[15:0]);
    if (cmd.n3) n3_r <= n3_full[47:16];
    if (cmd.coef) begin
      coef_r[0] <= (n3_s <<< 2) - (n2_s <<< 2) - (n2_s <<< 1) + (CW'(1) << 33);
      coef_r[1] <= n3_s - (n2_s <<< 1) + (n_s <<< 16);
      coef_r[2] <= (n2_s <<< 2) + (n2_s <<< 1) - (n3_s <<< 2);
      coef_r[3] <= n3_s - n2_s;
    end
    if (cmd.emit) begin
      out_re_r   <= sat18(64'(irnd_re >>> 33));
      out_im_r   <= sat18(64'(irnd_im >>> 33));
      out_last_r <= last;
    end
    if (!rst_n) begin
      phase_r     <= '0;
      cnt_r       <= '0;
      j_r         <= '0;
      tv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tv_r <= cmd.term_step;
      if (cmd.push) cnt_r <= '0;
      if (cmd.coef) begin
        j_r       <= '0;
        iacc_re_r <= '0;
        iacc_im_r <= '0;
      end
      if (cmd.term_step) j_r <= j_r + 3'd1;
      if (tv_r) begin
        iacc_re_r <= iacc_re_r + IAW'(iprod_re_r);
        iacc_im_r <= iacc_im_r + IAW'(iprod_im_r);
      end
      if (cmd.emit) begin
        phase_r     <= phase_sat;
        cnt_r       <= cnt_r + 7'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) phase_r <= (phase_r >= PHASE_ONE) ? phase_r - PHASE_ONE : '0;
    end
  end

  assign sts.clr_done  = (clr_cnt_r == AW'(HD - 1));
  assign sts.k_done    = (k_r >= ntaps);
  assign sts.term_done = (j_r == 3'd4);
  assign sts.busy      = v1_r | v2_r | tv_r;
  assign sts.warm      = (32'(warmup_r) >= 32'(ntaps) + 32'd3);
  assign sts.loop_go   = (phase_r < PHASE_ONE) && (cnt_r < 7'(MAX_RESULTS));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;
  assign out_last  = out_last_r;

endmodule

### hdl/fir_shaped_noise_spline_upsampler_core.sv
// FIR-shaped complex noise with Catmull-Rom upsampling. After reset the block sweeps all
// 2^ceil(log2(MAX_TAPS)) tap and history memory entries to zero with in ready low. A tap
// load leaves the block idle. A sample push runs one shared complex multiply-accumulate over
// the min(tap_count, MAX_TAPS) active taps, one tap per cycle. Once the window is warm, each
// result goes through n^2, n^3, the weights and four terms on a shared multiplier pair, plus
// any wait on out ready; a push returns at most 64 results, the last flagged by last_of_run.
// Config registers are always ready and must be written while idle; the block does not check.
module fir_shaped_noise_spline_upsampler_core #(
  parameter int MAX_TAPS = 64
) (
  input logic         clk,
  input logic         rst_n,
  fsnsu_in_if.sink    in_ch,
  fsnsu_out_if.source out_ch,
  fsnsu_cfg_if.sink   cfg_ch
);
  import fsnsu_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic in_fire;

  assign in_ch.ready  = idle;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && idle;

  fsnsu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_op   (in_ch.op),
    .sts     (sts),
    .cmd     (cmd),
    .idle    (idle)
  );

  fsnsu_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .tap_index (in_ch.tap_index),
    .tap_value (in_ch.tap_value),
    .sample_re (in_ch.sample_re),
    .sample_im (in_ch.sample_im),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_re    (out_ch.out_re),
    .out_im    (out_ch.out_im),
    .out_last  (out_ch.last_of_run)
  );

  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_PUSH) |=> !in_ch.ready)
    else $error("push transaction did not start work");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("input ready during memory clear");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !in_ch.ready)
    else $error("result produced while idle");

endmodule

### bench/spline_noise_checker.sv
`timescale 1ns / 100ps

module spline_noise_checker #(
  parameter int MAX_TAPS = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  fsnsu_in_if   in_ch,
  fsnsu_out_if  out_ch,
  fsnsu_cfg_if  cfg_ch,
  output int    errors,
  output int    pending
);
  import fsnsu_pkg::*;

  typedef struct {
    logic signed [17:0] re;
    logic signed [17:0] im;
    logic               last;
  } point_t;

  point_t             exp_points[$];
  logic [20:0]        step_q;
  logic [6:0]         taps_q;
  logic signed [15:0] coef[MAX_TAPS];
  logic signed [15:0] hist_re[MAX_TAPS];
  logic signed [15:0] hist_im[MAX_TAPS];
  logic signed [17:0] win_re[4];
  logic signed [17:0] win_im[4];
  logic [20:0]        phase;
  int                 warm;

  initial begin
    errors  = 0;
    pending = 0;
    step_q  = PHASE_STEP_RST;
    taps_q  = TAP_COUNT_RST;
    phase   = '0;
    warm    = 0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      coef[k]    = '0;
      hist_re[k] = '0;
      hist_im[k] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      win_re[k] = '0;
      win_im[k] = '0;
    end
  end

  function automatic logic signed [17:0] clip18(longint x);
    logic signed [17:0] r;
    if (x > 131071) r = 18'sd131071;
    else if (x < -131072) r = -18'sd131072;
    else r = x[17:0];
    return r;
  endfunction

  function automatic logic signed [17:0] spline(longint p0, longint p1, longint p2,
                                                longint p3, longint n);
    longint n2, n3, h00, h01, c10, c11, acc;
    n2  = n * n;
    n3  = (n2 * n) >>> 16;
    h00 = 2 * n3 - 3 * n2 + (64'sd1 <<< 32);
    h01 = 3 * n2 - 2 * n3;
    c10 = n3 - 2 * n2 + n * 65536;
    c11 = n3 - n2;
    acc = 2 * h00 * p1 + c10 * (p2 - p0) + 2 * h01 * p2 + c11 * (p3 - p1);
    return clip18((acc + (64'sd1 <<< 32)) >>> 33);
  endfunction

  function automatic void predict_push(logic signed [15:0] re, logic signed [15:0] im);
    longint acc_re, acc_im;
    int     ntaps, cnt;
    logic [21:0] nxt;
    point_t p;
    acc_re = 0;
    acc_im = 0;
    cnt    = 0;
    for (int k = MAX_TAPS - 1; k > 0; k--) begin
      hist_re[k] = hist_re[k-1];
      hist_im[k] = hist_im[k-1];
    end
    hist_re[0] = re;
    hist_im[0] = im;
    ntaps = (taps_q > MAX_TAPS) ? MAX_TAPS : int'(taps_q);
    for (int k = 0; k < ntaps; k++) begin
      acc_re += longint'(coef[k]) * longint'(hist_re[k]);
      acc_im += longint'(coef[k]) * longint'(hist_im[k]);
    end
    for (int k = 0; k < 3; k++) begin
      win_re[k] = win_re[k+1];
      win_im[k] = win_im[k+1];
    end
    win_re[3] = clip18((acc_re + 16384) >>> 15);
    win_im[3] = clip18((acc_im + 16384) >>> 15);
    if (warm < MAX_TAPS + 3) warm++;
    if (warm < ntaps + 3) return;
    while (phase < PHASE_ONE && cnt < MAX_RESULTS) begin
      p.re   = spline(win_re[0], win_re[1], win_re[2], win_re[3], longint'(phase));
      p.im   = spline(win_im[0], win_im[1], win_im[2], win_im[3], longint'(phase));
      p.last = 1'b0;
      exp_points.push_back(p);
      cnt++;
      nxt   = {1'b0, phase} + {1'b0, step_q};
      phase = (nxt > {1'b0, PHASE_MAX}) ? PHASE_MAX : nxt[20:0];
    end
    if (cnt > 0) exp_points[exp_points.size() - 1].last = 1'b1;
    if (phase >= PHASE_ONE) phase = phase - PHASE_ONE;
    else phase = '0;
  endfunction

  always @(posedge clk) begin
    point_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction re=%0d im=%0d last=%0b", $time,
                   out_ch.out_re, out_ch.out_im, out_ch.last_of_run);
        end else begin
          e = exp_points.pop_front();
          if (out_ch.out_re !== e.re || out_ch.out_im !== e.im ||
              out_ch.last_of_run !== e.last) begin
            errors++;
            $display("%0t: mismatch expected re=%0d im=%0d last=%0b actual re=%0d im=%0d last=%0b",
                     $time, e.re, e.im, e.last, out_ch.out_re, out_ch.out_im,
                     out_ch.last_of_run);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_PHASE_STEP) step_q = cfg_ch.data;
        else taps_q = cfg_ch.data[6:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_LOAD_TAP) coef[in_ch.tap_index] = in_ch.tap_value;
        else predict_push(in_ch.sample_re, in_ch.sample_im);
      end
    end
    pending <= exp_points.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import fsnsu_pkg::*;

  logic clk;
  logic rst_n;
  bit   hold_req;
  int   errors;
  int   pending;

  fsnsu_in_if  in_ch ();
  fsnsu_out_if out_ch ();
  fsnsu_cfg_if cfg_ch ();

  fir_shaped_noise_spline_upsampler_core #(.MAX_TAPS(64)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  spline_noise_checker #(.MAX_TAPS(64)) u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [15:0] rand16();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h7FFF;
    if (r < 16) return 16'h8000;
    if (r < 20) return 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send(logic op, logic [5:0] idx, logic [15:0] tv,
                      logic [15:0] re, logic [15:0] im);
    int g;
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.tap_index <= idx;
    in_ch.tap_value <= tv;
    in_ch.sample_re <= re;
    in_ch.sample_im <= im;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random();
    if ($urandom_range(0, 3) == 0) begin
      send(OP_LOAD_TAP, 6'($urandom), rand16(), 16'($urandom), 16'($urandom));
    end else begin
      send(OP_PUSH, 6'($urandom), 16'($urandom), rand16(), rand16());
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [20:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (2500) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  logic [20:0] step_set[6];
  logic [6:0]  taps_set[6];

  initial begin
    rst_n           = 1'b0;
    hold_req        = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_PUSH;
    in_ch.tap_index = '0;
    in_ch.tap_value = '0;
    in_ch.sample_re = '0;
    in_ch.sample_im = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_PHASE_STEP;
    cfg_ch.data     = '0;
    step_set = '{21'd1024, 21'd1048576, 21'h1FFFFF, 21'd65536, 21'd0, 21'd3000};
    taps_set = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd0, 7'd3};
    step_set[4] = 21'($urandom_range(1024, 1048576));
    taps_set[4] = 7'($urandom_range(1, 64));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_PHASE_STEP, 21'd16384);
    write_reg(REG_TAP_COUNT, 21'd2);
    send(OP_LOAD_TAP, 6'd0, 16'h7FFF, 16'h0, 16'h0);
    send(OP_LOAD_TAP, 6'd1, 16'h8000, 16'h0, 16'h0);
    send(OP_LOAD_TAP, 6'd63, 16'h1234, 16'h0, 16'h0);
    send(OP_LOAD_TAP, 6'd2, 16'h4000, 16'hFFFF, 16'hFFFF);
    send(OP_PUSH, 6'd0, 16'h0, 16'h7FFF, 16'h8000);
    send(OP_PUSH, 6'd0, 16'h0, 16'h8000, 16'h7FFF);
    send(OP_PUSH, 6'd0, 16'h0, 16'h7FFF, 16'h7FFF);
    send(OP_PUSH, 6'd0, 16'h0, 16'h8000, 16'h8000);
    send(OP_PUSH, 6'd0, 16'h0, 16'h0000, 16'h0000);
    send(OP_PUSH, 6'd0, 16'h0, 16'h7FFF, 16'h8000);
    send(OP_PUSH, 6'd63, 16'hFFFF, 16'h0001, 16'hFFFF);
    send(OP_PUSH, 6'd0, 16'h0, 16'h8000, 16'h7FFF);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PHASE_STEP, step_set[ph]);
      write_reg(REG_TAP_COUNT, {14'd0, taps_set[ph]});
      for (int i = 0; i < 72; i++) begin
        if (ph == 0 && i == 10) hold_req = 1'b1;
        if (ph == 3 && i == 36) wait_idle();
        send_random();
      end
      wait_idle();
    end

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hdl/fsnsu_pkg.sv
hdl/fsnsu_ifs.sv
hdl/fsnsu_ctrl.sv
hdl/fsnsu_dp.sv
hdl/fir_shaped_noise_spline_upsampler_core.sv
bench/spline_noise_checker.sv
bench/tb.sv
